/* rtl/nsd_pkg.sv */
// netstring deframer package: shared types, codes and character constants
// used by the core, the output buffer and the top level; no dependencies
`default_nettype none

package nsd_pkg;

   // width of the length counters in the frame state
   localparam int LEN_WIDTH = 24;

   // fixed widths of the interface fields
   localparam int BYTE_W = 8;
   localparam int SLEN_W = 24;
   localparam int ERR_W  = 3;
   localparam int KIND_W = 2;

   // packed result data: out_byte, string_length, error_code, padded to bytes
   localparam int RSP_FIELDS_W = BYTE_W + SLEN_W + ERR_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_DATA_W - RSP_FIELDS_W;

   // reset value of the max_length register
   localparam logic [SLEN_W-1:0] MAX_LENGTH_RESET = SLEN_W'(16384);

   // characters of the frame syntax
   localparam logic [BYTE_W-1:0] CHAR_COLON = 8'h3A;
   localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // result kinds
   typedef enum logic [KIND_W-1:0] {
      KIND_BYTE = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // error codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE     = 3'd0,
      ERR_CHAR     = 3'd1,
      ERR_NODIGIT  = 3'd2,
      ERR_LEADZERO = 3'd3,
      ERR_TOOLONG  = 3'd4,
      ERR_COMMA    = 3'd5
   } err_type;

   // one result item
   typedef struct packed {
      kind_type          kind;
      logic [BYTE_W-1:0] data;
      logic [SLEN_W-1:0] length;
      err_type           code;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/nsd_core.sv */
// netstring deframer core: frame state machine, length collection and
// max_length register; produces at most one result per byte; uses nsd_pkg
`default_nettype none

module nsd_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [nsd_pkg::SLEN_W-1:0]    csr_wdata,
   input  wire logic                          byte_accept,
   input  wire logic [nsd_pkg::BYTE_W-1:0]    byte_in,
   output logic                               result_valid,
   output nsd_pkg::rsp_type                   result
);
   import nsd_pkg::*;

   typedef enum logic [1:0] {
      PH_LEN   = 2'd0,
      PH_PAY   = 2'd1,
      PH_COMMA = 2'd2
   } phase_type;

   localparam int PROD_W = LEN_WIDTH + 4;

   phase_type              phase_ff, phase_in;
   logic [LEN_WIDTH-1:0]   length_ff, length_in;
   logic [LEN_WIDTH-1:0]   left_ff, left_in;
   logic                   digit_seen_ff, digit_seen_in;
   logic                   first_zero_ff, first_zero_in;
   logic [SLEN_W-1:0]      max_length_ff;

   logic [LEN_WIDTH-1:0]   limit;
   logic [3:0]             digit;
   logic [PROD_W-1:0]      next_value;
   logic [LEN_WIDTH-1:0]   left_dec;

   // length times ten plus the new digit, shift-and-add
   always_comb begin
      limit      = LEN_WIDTH'(max_length_ff);
      digit      = 4'(byte_in - CHAR_ZERO);
      next_value = (PROD_W'(length_ff) << 3) + (PROD_W'(length_ff) << 1) + PROD_W'(digit);
      left_dec   = left_ff - LEN_WIDTH'(1);
   end

   // next frame state and the result for this byte
   always_comb begin
      phase_in      = phase_ff;
      length_in     = length_ff;
      left_in       = left_ff;
      digit_seen_in = digit_seen_ff;
      first_zero_in = first_zero_ff;
      result_valid  = 1'b0;
      result.kind   = KIND_BYTE;
      result.data   = '0;
      result.length = '0;
      result.code   = ERR_NONE;

      case (phase_ff)
         PH_PAY: begin
            left_in      = left_dec;
            if (left_dec == '0) phase_in = PH_COMMA;
            result_valid = 1'b1;
            result.data  = byte_in;
         end
         PH_COMMA: begin
            result_valid = 1'b1;
            phase_in      = PH_LEN;
            length_in     = '0;
            left_in       = '0;
            digit_seen_in = 1'b0;
            first_zero_in = 1'b0;
            if (byte_in == CHAR_COMMA) begin
               result.kind   = KIND_END;
               result.length = SLEN_W'(length_ff);
            end else begin
               result.kind = KIND_ERR;
               result.code = ERR_COMMA;
            end
         end
         default: begin
            // reading length digits
            if (byte_in inside {[CHAR_ZERO:CHAR_NINE]}) begin
               if (digit_seen_ff && first_zero_ff) begin
                  result_valid = 1'b1;
                  result.kind  = KIND_ERR;
                  result.code  = ERR_LEADZERO;
               end else if (next_value > PROD_W'(limit)) begin
                  result_valid = 1'b1;
                  result.kind  = KIND_ERR;
                  result.code  = ERR_TOOLONG;
               end else begin
                  if (!digit_seen_ff) first_zero_in = (byte_in == CHAR_ZERO);
                  digit_seen_in = 1'b1;
                  length_in     = LEN_WIDTH'(next_value);
               end
            end else if (byte_in == CHAR_COLON) begin
               if (!digit_seen_ff) begin
                  result_valid = 1'b1;
                  result.kind  = KIND_ERR;
                  result.code  = ERR_NODIGIT;
               end else begin
                  left_in  = length_ff;
                  phase_in = (length_ff == '0) ? PH_COMMA : PH_PAY;
               end
            end else begin
               result_valid = 1'b1;
               result.kind  = KIND_ERR;
               result.code  = ERR_CHAR;
            end
            // any error restarts the length field
            if (result_valid) begin
               phase_in      = PH_LEN;
               length_in     = '0;
               left_in       = '0;
               digit_seen_in = 1'b0;
               first_zero_in = 1'b0;
            end
         end
      endcase
   end

   // frame state and limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN;
         length_ff     <= '0;
         left_ff       <= '0;
         digit_seen_ff <= 1'b0;
         first_zero_ff <= 1'b0;
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         if (byte_accept) begin
            phase_ff      <= phase_in;
            length_ff     <= length_in;
            left_ff       <= left_in;
            digit_seen_ff <= digit_seen_in;
            first_zero_ff <= first_zero_in;
         end
         if (csr_we) max_length_ff <= csr_wdata;
      end
   end

endmodule

`default_nettype wire

/* rtl/nsd_outbuf.sv */
// netstring deframer output buffer: result register with a one-entry skid
// register; the input side waits only while the skid entry is full; uses nsd_pkg
`default_nettype none

module nsd_outbuf (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire nsd_pkg::rsp_type  push_data,
   output logic                   can_push,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output nsd_pkg::rsp_type       out_data
);
   import nsd_pkg::*;

   logic     main_valid_ff, main_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   rsp_type  main_ff, main_in;
   rsp_type  skid_ff, skid_in;
   logic     pop;

   // room as long as the skid entry is free
   assign can_push  = !skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;
   assign pop       = main_valid_ff && out_ready;

   // refill the result register from skid first, then from the core
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   // result and skid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

/* rtl/netstring_deframer.sv */
// Netstring deframer: takes a byte stream of frames "length:payload," at one
// byte per cycle while req_tready is high, with no gaps of its own. Each
// payload byte comes out as a result of kind 0, the closing comma as kind 1
// with the declared length, and a malformed frame as one kind 2 result with
// an error code, after which the next byte starts a new length field. Lengths
// above max_length are rejected on the digit that exceeds it. Results go to a
// result register with a one-entry skid stage that keeps input acceptance
// independent of rsp_tready, so req_tready drops only when both hold a result.
// The user must write max_length through csr_we/csr_wdata only while idle;
// the block does not enforce this. Depends on nsd_pkg, nsd_core and nsd_outbuf.
`default_nettype none

module netstring_deframer (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // configuration: max_length
   input  wire logic                              csr_we,
   input  wire logic [nsd_pkg::SLEN_W-1:0]        csr_wdata,
   // input stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [nsd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] in_byte
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [nsd_pkg::RSP_DATA_W-1:0]         rsp_tdata,   // [7:0] out_byte,
                                                               // [31:8] string_length,
                                                               // [34:32] error_code
   output logic [nsd_pkg::KIND_W-1:0]             rsp_tuser    // [1:0] out_kind
);
   import nsd_pkg::*;

   logic     byte_accept;
   logic     result_valid;
   rsp_type  result;
   rsp_type  out_data;
   logic     can_push;

   assign req_tready  = can_push;
   assign byte_accept = req_tvalid && can_push;

   // frame decoding
   nsd_core u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_wdata    (csr_wdata),
      .byte_accept  (byte_accept),
      .byte_in      (req_tdata),
      .result_valid (result_valid),
      .result       (result)
   );

   // result register and skid stage
   nsd_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (byte_accept && result_valid),
      .push_data (result),
      .can_push  (can_push),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (out_data)
   );

   // pack the result fields
   assign rsp_tdata = {{RSP_PAD_W{1'b0}}, out_data.code, out_data.length, out_data.data};
   assign rsp_tuser = out_data.kind;

endmodule

`default_nettype wire

/* bench/netstring_deframer_tb.sv */
// self-checking bench for the netstring deframer: drives raw byte streams
// with random gaps and back-pressure and checks every result transfer
// against a cycle-free frame predictor; depends on nsd_pkg and the rtl
module netstring_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import nsd_pkg::*;

   // frame position as seen by the predictor
   typedef enum logic [1:0] {
      FR_LENGTH  = 2'd0,
      FR_PAYLOAD = 2'd1,
      FR_COMMA   = 2'd2
   } frame_phase_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [SLEN_W-1:0]     csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;

   // predictor state
   frame_phase_type       fr_phase;
   logic [LEN_WIDTH-1:0]  fr_length;
   logic [LEN_WIDTH-1:0]  fr_left;
   bit                    fr_digit;
   bit                    fr_zero_first;
   logic [SLEN_W-1:0]     max_len_cfg;

   rsp_type               pending_rsp[$];

   // bookkeeping
   int                    mismatch_count = 0;
   int                    sent_bytes = 0;
   int                    byte_results = 0;
   int                    end_results = 0;
   int                    error_results = 0;
   int                    stall_cycles = 0;
   int                    csr_writes = 0;
   bit                    calm = 1'b0;
   int                    rsp_hold_req = 0;
   int                    rsp_hold_left = 0;

   netstring_deframer u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("timeout with %0d results outstanding", pending_rsp.size());
      $display("netstring_deframer: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------

   function automatic void clear_frame();
      fr_phase      = FR_LENGTH;
      fr_length     = '0;
      fr_left       = '0;
      fr_digit      = 1'b0;
      fr_zero_first = 1'b0;
   endfunction

   function automatic rsp_type frame_error(input err_type code);
      rsp_type r;
      clear_frame();
      r = '{kind: KIND_ERR, data: '0, length: '0, code: code};
      return r;
   endfunction

   // one byte in, returns 1 with the result when the byte causes one
   function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output rsp_type r);
      logic [63:0] grown;
      r = '{kind: KIND_BYTE, data: '0, length: '0, code: ERR_NONE};
      case (fr_phase)
         FR_PAYLOAD: begin
            fr_left = fr_left - LEN_WIDTH'(1);
            if (fr_left == '0)
               fr_phase = FR_COMMA;
            r.data = b;
            return 1'b1;
         end
         FR_COMMA: begin
            if (b != CHAR_COMMA) begin
               r = frame_error(ERR_COMMA);
               return 1'b1;
            end
            r.kind   = KIND_END;
            r.length = fr_length;
            clear_frame();
            return 1'b1;
         end
         default: begin
            // length field
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
               if (fr_digit && fr_zero_first) begin
                  r = frame_error(ERR_LEADZERO);
                  return 1'b1;
               end
               grown = 64'(fr_length) * 64'd10 + 64'(b - CHAR_ZERO);
               if (grown > 64'(max_len_cfg)) begin
                  r = frame_error(ERR_TOOLONG);
                  return 1'b1;
               end
               if (!fr_digit)
                  fr_zero_first = (b == CHAR_ZERO);
               fr_digit  = 1'b1;
               fr_length = grown[LEN_WIDTH-1:0];
               return 1'b0;
            end
            if (b == CHAR_COLON) begin
               if (!fr_digit) begin
                  r = frame_error(ERR_NODIGIT);
                  return 1'b1;
               end
               fr_left  = fr_length;
               fr_phase = (fr_length == '0) ? FR_COMMA : FR_PAYLOAD;
               return 1'b0;
            end
            r = frame_error(ERR_CHAR);
            return 1'b1;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("ERROR at %0t: %s", $realtime, msg);
   endtask

   // receiver readiness, with requested hold-offs counted here
   always @(posedge clock) begin
      if (rsp_hold_req != 0) begin
         rsp_hold_left = rsp_hold_req;
         rsp_hold_req  = 0;
      end
      if (rsp_hold_left != 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 18);
      end
   end

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin : check_results
      rsp_type seen;
      rsp_type want;
      if (!reset && req_tvalid && !req_tready)
         stall_cycles++;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.kind   = kind_type'(rsp_tuser);
         seen.data   = rsp_tdata[BYTE_W-1:0];
         seen.length = rsp_tdata[BYTE_W +: SLEN_W];
         seen.code   = err_type'(rsp_tdata[BYTE_W+SLEN_W +: ERR_W]);
         case (seen.kind)
            KIND_BYTE: byte_results++;
            KIND_END:  end_results++;
            default:   error_results++;
         endcase
         if (pending_rsp.size() == 0) begin
            note_mismatch($sformatf("unexpected result kind=%0d byte=%02h len=%0d code=%0d",
                                    seen.kind, seen.data, seen.length, seen.code));
         end else begin
            want = pending_rsp.pop_front();
            if (seen.kind !== want.kind || seen.data !== want.data ||
                seen.length !== want.length || seen.code !== want.code)
               note_mismatch($sformatf(
                  "expected kind=%0d byte=%02h len=%0d code=%0d, got kind=%0d byte=%02h len=%0d code=%0d",
                  want.kind, want.data, want.length, want.code,
                  seen.kind, seen.data, seen.length, seen.code));
         end
      end
   end

   // ---------------------------------------------------------------
   // input side
   // ---------------------------------------------------------------

   // one byte transfer; valid stays high so the next call can follow at once
   task automatic send_byte(input logic [BYTE_W-1:0] b);
      rsp_type r;
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      if (deframe_byte(b, r))
         pending_rsp.push_back(r);
      sent_bytes++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(s[i]);
   endtask

   task automatic send_number(input longint unsigned n);
      send_text($sformatf("%0d", n));
   endtask

   task automatic send_payload(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   // stop offering and let every predicted result come out
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_length(input logic [SLEN_W-1:0] v);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we      <= 1'b0;
      max_len_cfg  = v;
      csr_writes++;
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // well-formed frames and each error at the reset limit
   task automatic test_directed_frames();
      send_text("0:,");                 // lone zero, empty payload
      send_text("2:");
      send_byte(8'h00);
      send_byte(8'hFF);
      send_text(",");
      send_text(":");                   // colon with no digit
      send_text("01");                  // leading zero
      send_text("16385");               // one above the reset limit
      send_text("1:ab");                // b stands where the comma belongs
      send_text("16384x");              // limit accepted, then a stray char
      send_text("2::,,");               // syntax chars inside the payload
   endtask

   // register extremes and a small limit
   task automatic test_length_limits();
      write_max_length('0);
      send_text("0:,");
      send_text("1");
      write_max_length('1);
      send_text("16777215x");
      send_text("16777216");
      send_text("99999999");
      write_max_length(SLEN_W'(5));
      send_text("5:abcde,");
      send_text("10");
      send_text("3:xyz;");
   endtask

   // receiver holds off long enough for the block to stall its input
   task automatic test_backpressure();
      write_max_length(SLEN_W'(64));
      calm         = 1'b1;
      rsp_hold_req = 300;
      for (int k = 0; k < 3; k++) begin
         send_text("30:");
         send_payload(30);
         send_text(",");
      end
      calm = 1'b0;
      wait_for_drain();
   endtask

   // sender pauses mid-stream until every result has come
   task automatic test_sender_pause();
      send_text("4:");
      send_payload(4);
      wait_for_drain();
      send_text(",");
      send_text("3:");
      send_payload(3);
      send_text(",");
      wait_for_drain();
   endtask

   // one random frame, mostly well formed, sometimes broken or noise
   task automatic send_random_frame();
      int unsigned     pick;
      int unsigned     len;
      int unsigned     cap;
      logic [BYTE_W-1:0] junk;
      cap  = (max_len_cfg < 24) ? max_len_cfg : 24;
      len  = $urandom_range(cap);
      pick = $urandom_range(99);
      if (pick < 70) begin
         send_number(len);
         send_text(":");
         send_payload(len);
         send_text(",");
      end else if (pick < 76) begin
         send_number(len);
         send_text(":");
         send_payload(len);
         do junk = 8'($urandom_range(255)); while (junk == CHAR_COMMA);
         send_byte(junk);
      end else if (pick < 81) begin
         send_text("0");
         send_number(len);
         send_text(":");
      end else if (pick < 86) begin
         send_number(longint'(max_len_cfg) + 1 + $urandom_range(1000));
      end else if (pick < 90) begin
         send_text(":");
      end else if (pick < 95) begin
         send_number($urandom_range(cap));
         do junk = 8'($urandom_range(255));
         while ((junk >= CHAR_ZERO && junk <= CHAR_NINE) || junk == CHAR_COLON);
         send_byte(junk);
      end else begin
         send_byte(8'($urandom_range(255)));
      end
   endtask

   // random traffic over several limit settings, one stretch without gaps
   task automatic test_random_traffic();
      logic [SLEN_W-1:0] limits [6];
      int                goal;
      limits = '{SLEN_W'(37), SLEN_W'(0), '1, SLEN_W'(1),
                 SLEN_W'($urandom_range(2, 200)), SLEN_W'(9)};
      goal   = sent_bytes;
      for (int p = 0; p < 6; p++) begin
         write_max_length(limits[p]);
         calm  = (p == 3);
         goal += 100;
         while (sent_bytes < goal)
            send_random_frame();
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------
   initial begin
      max_len_cfg = MAX_LENGTH_RESET;
      clear_frame();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_frames();
      test_length_limits();
      test_backpressure();
      test_sender_pause();
      test_random_traffic();

      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("run covered %0d input bytes and %0d register writes, %0d input stall cycles",
               sent_bytes, csr_writes, stall_cycles);
      $display("results seen: %0d payload bytes, %0d frame ends, %0d errors",
               byte_results, end_results, error_results);
      if (mismatch_count == 0)
         $display("netstring_deframer: match");
      else
         $display("netstring_deframer: mismatch");
      $finish;
   end

endmodule
